[hdl/ect_pkg.sv]
// Shared types, command codes and constants for the extended compare timer.
package ect_pkg;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_ONESHOT  = 2'd1;
  localparam logic [1:0] CMD_PERIODIC = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  // ceil(2^36 / 125): (ticks >> 3) * ECT_MS_RECIP >> 36 equals ticks / 1000 for 32-bit ticks
  localparam logic [29:0] ECT_MS_RECIP = 30'd549755814;
  localparam int          ECT_MS_SHIFT = 36;

  localparam int ECT_FIFO_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] delay_ticks;
  } ect_in_t;

  typedef struct packed {
    logic        fire;
    logic [31:0] time_ticks;
    logic [22:0] time_ms;
    logic        armed;
  } ect_out_t;

  typedef struct packed {
    logic        fire;
    logic [31:0] time_ticks;
    logic        armed;
  } ect_tick_t;

  typedef struct packed {
    logic s0_valid;
    logic s1_valid;
  } ect_flight_t;

endpackage

[hdl/ect_core.sv]
// Input register, counter and compare channel state, and the per-beat result register.
module ect_core import ect_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  ect_in_t     in_item,
  output ect_flight_t flight,
  output ect_tick_t   res
);

  logic        s0_v_r;
  ect_in_t     s0_r;
  logic        s1_v_r;
  ect_tick_t   s1_r;
  ect_tick_t   s1_nxt;

  logic [15:0] count_low_r, count_low_nxt;
  logic [15:0] count_high_r, count_high_nxt;
  logic [15:0] compare_value_r, compare_value_nxt;
  logic [15:0] matches_left_r, matches_left_nxt;
  logic        armed_r, armed_nxt;
  logic [31:0] period_r, period_nxt;
  logic [15:0] cnt_inc;
  logic        fire;

  always_comb begin
    count_low_nxt     = count_low_r;
    count_high_nxt    = count_high_r;
    compare_value_nxt = compare_value_r;
    matches_left_nxt  = matches_left_r;
    armed_nxt         = armed_r;
    period_nxt        = period_r;
    fire              = 1'b0;
    cnt_inc           = count_low_r + 16'd1;
    unique case (s0_r.cmd)
      CMD_TICK: begin
        count_low_nxt = cnt_inc;
        if (cnt_inc == 16'd0) begin
          count_high_nxt = count_high_r + 16'd1;
        end
        if (armed_r && (cnt_inc == compare_value_r)) begin
          if (matches_left_r == 16'd0) begin
            armed_nxt = 1'b0;
            fire      = 1'b1;
            // re-arm from the stored period, relative to the advanced count
            if (period_r != 32'd0) begin
              matches_left_nxt  = period_r[31:16];
              compare_value_nxt = cnt_inc + period_r[15:0];
              armed_nxt         = 1'b1;
            end
          end else begin
            matches_left_nxt = matches_left_r - 16'd1;
          end
        end
      end
      CMD_ONESHOT: begin
        matches_left_nxt  = s0_r.delay_ticks[31:16];
        compare_value_nxt = count_low_r + s0_r.delay_ticks[15:0];
        armed_nxt         = 1'b1;
      end
      CMD_PERIODIC: begin
        if (s0_r.delay_ticks == 32'd0) begin
          armed_nxt  = 1'b0;
          period_nxt = 32'd0;
        end else begin
          period_nxt        = s0_r.delay_ticks;
          matches_left_nxt  = s0_r.delay_ticks[31:16];
          compare_value_nxt = count_low_r + s0_r.delay_ticks[15:0];
          armed_nxt         = 1'b1;
        end
      end
      CMD_READ: begin
      end
      default: begin
      end
    endcase
    s1_nxt.fire       = fire;
    s1_nxt.time_ticks = {count_high_nxt, count_low_nxt};
    s1_nxt.armed      = armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r          <= 1'b0;
      s1_v_r          <= 1'b0;
      count_low_r     <= 16'd0;
      count_high_r    <= 16'd0;
      compare_value_r <= 16'd0;
      matches_left_r  <= 16'd0;
      armed_r         <= 1'b0;
      period_r        <= 32'd0;
    end else begin
      s0_v_r <= in_fire;
      s1_v_r <= s0_v_r;
      if (s0_v_r) begin
        count_low_r     <= count_low_nxt;
        count_high_r    <= count_high_nxt;
        compare_value_r <= compare_value_nxt;
        matches_left_r  <= matches_left_nxt;
        armed_r         <= armed_nxt;
        period_r        <= period_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_r <= in_item;
    end
    if (s0_v_r) begin
      s1_r <= s1_nxt;
    end
  end

  assign flight.s0_valid = s0_v_r;
  assign flight.s1_valid = s1_v_r;
  assign res             = s1_r;

endmodule

[hdl/ect_ms.sv]
// Tick time to milliseconds by reciprocal multiply, and assembly of the result beat.
module ect_ms import ect_pkg::*; (
  input  ect_tick_t tick,
  output ect_out_t  beat
);

  logic [58:0] prod;

  assign prod = 59'(tick.time_ticks[31:3]) * 59'(ECT_MS_RECIP);

  assign beat.fire       = tick.fire;
  assign beat.time_ticks = tick.time_ticks;
  assign beat.time_ms    = prod[ECT_MS_SHIFT +: 23];
  assign beat.armed      = tick.armed;

endmodule

[hdl/ect_fifo.sv]
// Result queue that decouples the timer pipeline from the output handshake.
module ect_fifo import ect_pkg::*; #(
  parameter int FIFO_DEPTH = ECT_FIFO_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  ect_out_t                          push_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output ect_out_t                          out_data,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]   count
);

  localparam int PtrW = $clog2(FIFO_DEPTH);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  ect_out_t            mem [FIFO_DEPTH];
  logic [PtrW-1:0]     wr_ptr_r;
  logic [PtrW-1:0]     rd_ptr_r;
  logic [CntW-1:0]     count_r;
  logic                pop;

  assign pop       = out_ready && (count_r != '0);
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

[hdl/extended_compare_timer.sv]
// Extended compare timer: 32-bit tick time with one compare channel and ms readout.
// An accepted beat passes s0, s1 and the result queue before it is offered on the output.
// Throughput: one beat per cycle if in_ready; counter/compare is a single registered pass.
// in_ready comes from registered occupancy (pipeline plus a FIFO_DEPTH-entry result queue).
// Reset (rst_n low, synchronous) clears counter, compare channel, period and the queue.
module extended_compare_timer import ect_pkg::*; #(
  parameter int FIFO_DEPTH = ECT_FIFO_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ect_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ect_out_t out_data
);

  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  ect_flight_t     flight;
  ect_tick_t       tick;
  ect_out_t        beat;
  logic [CntW-1:0] q_count;
  logic [CntW:0]   occupancy;
  logic            in_fire;

  // hold off input while every queue slot is spoken for by stored or in-flight beats
  assign occupancy = {1'b0, q_count} + (CntW + 1)'(flight.s0_valid)
                   + (CntW + 1)'(flight.s1_valid);
  assign in_ready  = (occupancy < (CntW + 1)'(FIFO_DEPTH));
  assign in_fire   = in_valid && in_ready;

  ect_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_data),
    .flight  (flight),
    .res     (tick)
  );

  ect_ms u_ms (
    .tick (tick),
    .beat (beat)
  );

  ect_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (flight.s1_valid),
    .push_data (beat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .count     (q_count)
  );

endmodule
